// ===== src/slaw_pkg.sv =====
// Package for the subtile layout address walker.
// Field widths, tile geometry, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package slaw_pkg;

    localparam int TILE_SIDE    = 8;
    localparam int TILE_LOG2    = 3;
    localparam int MAX_DIM      = 256;
    localparam int MAX_ITEM     = 8;

    localparam int DIM_W        = 9;
    localparam int ITEM_W       = 4;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int OFFSET_W     = 27;
    localparam int RUN_W        = 15;
    localparam int TCOUNT_W     = 5;   // tile row / column counters
    localparam int NTILE_W      = 6;   // tile counts, up to MAX_DIM / TILE_SIDE
    localparam int ROW_W        = 3;   // row inside a tile

    localparam int ROWB_W       = 12;  // dim2 * item bytes
    localparam int PLANE_W      = 20;  // dim1 * dim2 * item bytes

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM0_SIZE   = 3'd0,
        REG_DIM1_SIZE   = 3'd1,
        REG_DIM2_SIZE   = 3'd2,
        REG_ITEM_BYTES  = 3'd3,
        REG_TO_STANDARD = 3'd4
    } cfg_index_t;

    localparam logic [DIM_W-1:0]  DIM0_RESET  = 9'd64;
    localparam logic [DIM_W-1:0]  DIM1_RESET  = 9'd64;
    localparam logic [DIM_W-1:0]  DIM2_RESET  = 9'd64;
    localparam logic [ITEM_W-1:0] ITEM_RESET  = 4'd1;
    localparam logic              TO_STD_RESET = 1'b1;

    typedef struct packed {
        logic [OFFSET_W-1:0] src_offset;
        logic [OFFSET_W-1:0] dst_offset;
        logic [RUN_W-1:0]    run_bytes;
        logic                last;
    } result_t;

endpackage

// ===== src/subtile_layout_address_walker_top.sv =====
// Top level of the subtile layout address walker: descriptor generator.
// Depends on slaw_pkg.
`timescale 1ns / 1ps

// Usage
//   Configuration: cfg_wr_en / cfg_index / cfg_data write one register per
//   cycle (dim0, dim1, dim2, item bytes, direction). Write only while idle.
//   After any write, and after reset, in_stall stays high while the stride
//   products settle through two registered multipliers.
//   Input channel: each item carries restart; restart = 1 starts the brick
//   at its first run. Each accepted item produces one descriptor, except
//   when dim0 or dim1 holds fewer than one tile: then no result.
//   Output channel: src_offset, dst_offset, run_bytes and last; last marks
//   the final run, after which the walk wraps to the first run.
//   Throughput: one item per cycle while in_stall is low; offsets come from small counter-times-
//   stride products and one three-way add between the counters and the
//   output register.
//   Stall: a two-entry output (result register plus skid register) lets one
//   more item in while a result waits; in_stall rises once the skid is full.
//   Reset (rst_n low, asynchronous): registers return to their defaults, the
//   walk to its first run, both output entries empty.
module subtile_layout_address_walker_top
    import slaw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OFFSET_W-1:0]   src_offset,
    output logic [OFFSET_W-1:0]   dst_offset,
    output logic [RUN_W-1:0]      run_bytes,
    output logic                  last
);

    localparam logic [DIM_W-1:0]  DIM_CLAMP  = DIM_W'(MAX_DIM);
    localparam logic [ITEM_W-1:0] ITEM_CLAMP = ITEM_W'(MAX_ITEM);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(TILE_SIDE - 1);

    // configuration
    logic [DIM_W-1:0]  dim0_reg, dim1_reg, dim2_reg;
    logic [ITEM_W-1:0] item_reg;
    logic              to_std_reg;
    logic [1:0]        settle_reg;

    // stride products
    logic [ROWB_W-1:0]  rowb_reg;   // d2 * b
    logic [PLANE_W-1:0] plane_reg;  // d1 * d2 * b

    // walk position
    logic [TCOUNT_W-1:0] trow_reg, tcol_reg;
    logic [ROW_W-1:0]    rit_reg;

    // output entries
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic [DIM_W-1:0]   d0c, d1c, d2c;
    logic [ITEM_W-1:0]  bc;
    logic [NTILE_W-1:0] n0, n1;
    logic               empty_brick;
    logic               accept, push, pop;
    logic               oob;

    logic [TCOUNT_W-1:0] er, ec;
    logic [ROW_W-1:0]    ek;
    logic [TCOUNT_W-1:0] trow_next, tcol_next;
    logic [ROW_W-1:0]    rit_next;

    logic [RUN_W-1:0]         col_stride;     // 8 * d2 * b
    logic [OFFSET_W-1:0]      row_term;
    logic [OFFSET_W-1:0]      col_std_term, col_sub_term;
    logic [OFFSET_W-1:0]      k_std_term, k_sub_term;
    logic [OFFSET_W-1:0]      std_off, sub_off;
    result_t                  res_next;

    always_comb
    begin
        d0c = (dim0_reg > DIM_CLAMP) ? DIM_CLAMP : dim0_reg;
        d1c = (dim1_reg > DIM_CLAMP) ? DIM_CLAMP : dim1_reg;
        d2c = (dim2_reg > DIM_CLAMP) ? DIM_CLAMP : dim2_reg;
        bc  = (item_reg > ITEM_CLAMP) ? ITEM_CLAMP : item_reg;
        n0  = NTILE_W'(d0c >> TILE_LOG2);
        n1  = NTILE_W'(d1c >> TILE_LOG2);
        empty_brick = (n0 == '0) || (n1 == '0);
    end

    assign in_stall  = (settle_reg != 2'd0) || skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign push      = accept && !empty_brick;
    assign pop       = out_valid_reg && !out_stall;

    // effective position: restart or a position past the current bounds
    // begins again at the first run
    always_comb
    begin
        oob = ({1'b0, trow_reg} >= n0) || ({1'b0, tcol_reg} >= n1);
        if (restart || oob)
        begin
            er = '0;
            ec = '0;
            ek = '0;
        end
        else
        begin
            er = trow_reg;
            ec = tcol_reg;
            ek = rit_reg;
        end
    end

    always_comb
    begin
        if (empty_brick)
        begin
            trow_next = '0;
            tcol_next = '0;
            rit_next  = '0;
        end
        else if (ek != ROW_LAST)
        begin
            trow_next = er;
            tcol_next = ec;
            rit_next  = ek + 1'b1;
        end
        else
        begin
            rit_next = '0;
            if (({1'b0, ec} + 1'b1) < n1)
            begin
                tcol_next = ec + 1'b1;
                trow_next = er;
            end
            else
            begin
                tcol_next = '0;
                if (({1'b0, er} + 1'b1) < n0)
                    trow_next = er + 1'b1;
                else
                    trow_next = '0;
            end
        end
    end

    // offsets: std = r*8*P + c*8*R + k*P, sub = r*8*P + c*64*R + k*8*R
    // with R = d2*b and P = d1*d2*b
    always_comb
    begin
        col_stride   = {rowb_reg, 3'b000};
        row_term     = OFFSET_W'({OFFSET_W'(er) * OFFSET_W'(plane_reg), 3'b000});
        col_std_term = OFFSET_W'(ec) * OFFSET_W'(col_stride);
        col_sub_term = OFFSET_W'({OFFSET_W'(ec) * OFFSET_W'(col_stride), 3'b000});
        k_std_term   = OFFSET_W'(ek) * OFFSET_W'(plane_reg);
        k_sub_term   = OFFSET_W'(ek) * OFFSET_W'(col_stride);
        std_off      = row_term + col_std_term + k_std_term;
        sub_off      = row_term + col_sub_term + k_sub_term;

        res_next.src_offset = to_std_reg ? sub_off : std_off;
        res_next.dst_offset = to_std_reg ? std_off : sub_off;
        res_next.run_bytes  = col_stride;
        res_next.last       = ({1'b0, er} == n0 - 1'b1) && ({1'b0, ec} == n1 - 1'b1)
                              && (ek == ROW_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim0_reg   <= DIM0_RESET;
            dim1_reg   <= DIM1_RESET;
            dim2_reg   <= DIM2_RESET;
            item_reg   <= ITEM_RESET;
            to_std_reg <= TO_STD_RESET;
            settle_reg <= 2'd2;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                settle_reg <= 2'd2;
                unique case (cfg_index)
                    REG_DIM0_SIZE:   dim0_reg   <= cfg_data[DIM_W-1:0];
                    REG_DIM1_SIZE:   dim1_reg   <= cfg_data[DIM_W-1:0];
                    REG_DIM2_SIZE:   dim2_reg   <= cfg_data[DIM_W-1:0];
                    REG_ITEM_BYTES:  item_reg   <= cfg_data[ITEM_W-1:0];
                    REG_TO_STANDARD: to_std_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // stride products, one multiplier per registered stage: rowb_reg, then plane_reg
    always_ff @(posedge clk)
    begin
        rowb_reg  <= ROWB_W'(d2c) * ROWB_W'(bc);
        plane_reg <= PLANE_W'(d1c) * PLANE_W'(rowb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trow_reg <= '0;
            tcol_reg <= '0;
            rit_reg  <= '0;
        end
        else if (accept)
        begin
            trow_reg <= trow_next;
            tcol_reg <= tcol_next;
            rit_reg  <= rit_next;
        end
    end

    // result register plus skid; a push never meets a full skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                if (!out_valid_reg || pop)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign src_offset = out_reg.src_offset;
    assign dst_offset = out_reg.dst_offset;
    assign run_bytes  = out_reg.run_bytes;
    assign last       = out_reg.last;

endmodule
